@@ sv/adcscan_pkg.sv @@
// ----------------------------------------------------------------------------
// adcscan_pkg
// Shared types and constants for the converter scan sequencer.
// ----------------------------------------------------------------------------
package adcscan_pkg;

	// Geometry
	localparam int CHANNELS    = 6;
	localparam int CH_BITS     = 3;
	localparam int SAMPLE_BITS = 10;
	localparam int DB_BITS     = 10;

	typedef logic [CH_BITS-1:0]     ch_t;
	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DB_BITS-1:0]     db_t;
	typedef logic [CHANNELS-1:0]    ch_mask_t;

	// Operation codes
	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_ACK     = 1'b1;

	// Register indexes
	localparam logic REG_ENABLE   = 1'b0;
	localparam logic REG_DEADBAND = 1'b1;

	localparam int   CFG_BITS       = 10;
	localparam db_t  DEADBAND_RESET = db_t'(2);

	typedef logic [CFG_BITS-1:0] cfg_data_t;

	// Request payload
	typedef struct packed {
		logic    operation;
		sample_t sample;
		ch_t     query_channel;
	} req_t;

	// Result payload
	typedef struct packed {
		logic    kept;
		logic    restart;
		ch_t     sampled_channel;
		logic    changed;
		ch_t     next_channel;
		logic    data_ready;
		sample_t query_reading;
	} rsp_t;

	// Control from the sequencer to the reading lanes
	typedef struct packed {
		logic    write_en;
		ch_t     cur;
		ch_t     query;
		sample_t sample;
	} lane_ctrl_t;

endpackage

@@ sv/adcscan_lanes.sv @@
// ----------------------------------------------------------------------------
// adcscan_lanes
// Per-channel stored readings, each with its own deadband compare.
// ----------------------------------------------------------------------------
module adcscan_lanes (
	input  logic                    clk,
	input  logic                    arst_n,
	input  adcscan_pkg::lane_ctrl_t ctrl,
	input  adcscan_pkg::db_t        deadband,
	output logic                    changed,
	output adcscan_pkg::sample_t    query_reading
);
	import adcscan_pkg::*;

	sample_t  reading_q [CHANNELS];
	ch_mask_t upd;

	// One lane per channel: difference against the new sample, update when selected
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			sample_t diff;
			diff = (reading_q[c] > ctrl.sample) ? reading_q[c] - ctrl.sample
			                                    : ctrl.sample - reading_q[c];
			upd[c] = ctrl.write_en && (ctrl.cur == ch_t'(c)) && (diff > deadband);
		end
	end

	assign changed = |upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) reading_q[c] <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (upd[c]) reading_q[c] <= ctrl.sample;
			end
		end
	end

	// Query sees the reading after this item's update
	always_comb begin
		if (ctrl.query < ch_t'(CHANNELS)) begin
			query_reading = upd[ctrl.query] ? ctrl.sample : reading_q[ctrl.query];
		end else begin
			query_reading = '0;
		end
	end

endmodule

@@ sv/adc_scan_sequencer_deadband_top.sv @@
// ----------------------------------------------------------------------------
// adc_scan_sequencer_deadband_top
// Round-robin converter scan sequencer: dummy discard, deadband update,
// data-ready handshake and reading query.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_data (req_t)
//  rsp       out        rsp_valid/rsp_stall  rsp_data (rsp_t)
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One request per cycle while req_stall is low; each request passes through
//  the input register, then the result register, before its result is valid.
//  Reset clears readings, scan state, enable mask and sets deadband to 2.
//  A skid register behind the result register lets one more request in while
//  a result is stalled; req_stall rises only when the skid is also full.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_deadband_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  adcscan_pkg::req_t      req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output adcscan_pkg::rsp_t      rsp_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  adcscan_pkg::cfg_data_t cfg_data
);
	import adcscan_pkg::*;

	// Configuration
	ch_mask_t enable_q;
	db_t      deadband_q;

	// Scan state
	ch_t  cur_q;
	logic dummy_q;
	logic ready_q;

	// Pipeline and output registers
	logic v_s1;
	req_t req_s1;
	logic rsp_v_q, skid_v_q;
	rsp_t rsp_q, skid_q;

	logic       fire, is_ack, is_dummy, is_keep;
	ch_t        pick, next_cur;
	rsp_t       res;
	lane_ctrl_t lane_ctrl;
	logic       lane_changed;
	sample_t    lane_query;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= '0;
			deadband_q <= DEADBAND_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[CHANNELS-1:0];
				REG_DEADBAND: deadband_q <= cfg_data[DB_BITS-1:0];
				default:      ;
			endcase
		end
	end

	// Input register
	assign req_stall = v_s1 && skid_v_q;
	assign fire      = v_s1 && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) req_s1 <= req_data;
	end

	// Item decode
	assign is_ack   = (req_s1.operation == OP_ACK);
	assign is_dummy = !is_ack && !dummy_q;
	assign is_keep  = !is_ack && dummy_q;

	// Rotating priority search from the channel after the current one
	always_comb begin
		pick = cur_q;
		for (int i = CHANNELS; i >= 1; i--) begin
			logic [CH_BITS:0] sum;
			ch_t              c;
			sum = {1'b0, cur_q} + (CH_BITS+1)'(i);
			if (sum >= (CH_BITS+1)'(CHANNELS)) sum = sum - (CH_BITS+1)'(CHANNELS);
			c = sum[CH_BITS-1:0];
			if (enable_q[c]) pick = c;
		end
	end

	assign next_cur = is_keep ? pick : cur_q;

	// Reading lanes
	assign lane_ctrl.write_en = fire && is_keep;
	assign lane_ctrl.cur      = cur_q;
	assign lane_ctrl.query    = req_s1.query_channel;
	assign lane_ctrl.sample   = req_s1.sample;

	adcscan_lanes u_lanes (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (lane_ctrl),
		.deadband      (deadband_q),
		.changed       (lane_changed),
		.query_reading (lane_query)
	);

	// Result word
	always_comb begin
		res.kept            = is_keep;
		res.restart         = is_dummy;
		res.sampled_channel = is_ack ? '0 : cur_q;
		res.changed         = lane_changed;
		res.next_channel    = next_cur;
		res.data_ready      = is_ack ? 1'b0 : (is_keep ? 1'b1 : ready_q);
		res.query_reading   = lane_query;
	end

	// Scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			dummy_q <= 1'b0;
			ready_q <= 1'b0;
		end else if (fire) begin
			cur_q   <= next_cur;
			ready_q <= res.data_ready;
			if (!is_ack) dummy_q <= !dummy_q;
		end
	end

	// Result register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!rsp_v_q || !rsp_stall) begin
			rsp_v_q  <= skid_v_q || fire;
			skid_v_q <= 1'b0;
		end else if (fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_v_q || !rsp_stall) begin
			if (skid_v_q)  rsp_q <= skid_q;
			else if (fire) rsp_q <= res;
		end else if (fire) begin
			skid_q <= res;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp_data  = rsp_q;

endmodule
